// File: hw/rtl/fbfl_pkg.sv
// shared types and constants for the fixed block free-list allocator
package fbfl_pkg;

  // field widths
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned INDEX_W       = 10;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned BLOCK_COUNT_W = 11;
  localparam int unsigned LINK_W        = 16;

  // end-of-list marker and reset pool size
  localparam logic [LINK_W-1:0] END_MARK = 16'hFFFF;
  localparam int unsigned RST_BLOCK_COUNT = 1024;

  // command codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } fbfl_op_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } fbfl_status_t;

  // input word
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  block_index;
  } fbfl_in_t;

  // result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
  } fbfl_out_t;

  // link memory request, addresses at full link width
  typedef struct packed {
    logic              wr_en;
    logic [LINK_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [LINK_W-1:0] rd_addr;
  } fbfl_mem_req_t;

endpackage

// File: hw/rtl/fbfl_link_mem.sv
// next-link memory: one write port, one registered read port
module fbfl_link_mem
  import fbfl_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk,
  input  fbfl_mem_req_t       req,
  output logic [LINK_W-1:0]   rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [LINK_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      link_mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= link_mem[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/fixed_block_free_list_allocator.sv
// top level of the fixed block free-list allocator: head register, sequencer, link memory
// free, unused code, empty allocate and empty init: result in the cycle after accept, busy stays low
// allocate: link read from memory, result registered after the S_READ state, busy during the read
// init: one memory write per block, busy until the list is threaded
// reset (rst_n low, synchronous) threads a pool of min(1024, MAX_BLOCKS) blocks through the
// memory write port: busy until it is threaded, config still taken
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  fbfl_in_t                 in_data,
  output logic                     out_valid,
  output fbfl_out_t                out_data,
  input  logic                     cfg_we,
  input  logic [BLOCK_COUNT_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
  localparam int unsigned COUNT_TOP = (1 << BLOCK_COUNT_W) - 1;
  localparam int unsigned CNT_MAX   = (MAX_BLOCKS < COUNT_TOP) ? MAX_BLOCKS : COUNT_TOP;
  localparam int unsigned CNT_W     = $clog2(CNT_MAX + 1);
  localparam int unsigned RST_CNT   = (CNT_MAX < RST_BLOCK_COUNT) ? CNT_MAX : RST_BLOCK_COUNT;
  localparam int unsigned CMP_W     = LINK_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_INIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [LINK_W-1:0]        free_head_r, free_head_nxt;
  logic [BLOCK_COUNT_W-1:0] block_count_r;
  logic [IDX_W-1:0]         walk_r, walk_nxt;
  logic [IDX_W-1:0]         last_r, last_nxt;
  logic                     quiet_r, quiet_nxt;
  logic                     out_valid_r, out_valid_nxt;
  fbfl_out_t                out_data_r, out_data_nxt;

  fbfl_mem_req_t            mem_req;
  logic [LINK_W-1:0]        mem_rd_data;

  logic                     accept;
  logic                     head_empty;
  logic [CNT_W-1:0]         eff_cnt;
  logic [LINK_W-1:0]        free_idx;

  // link memory
  fbfl_link_mem #(
    .DEPTH (MAX_BLOCKS)
  ) u_link_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  assign accept     = start && !busy;
  assign busy       = (state_r != S_IDLE);
  assign head_empty = (free_head_r >= LINK_W'(MAX_BLOCKS));
  assign free_idx   = LINK_W'(in_data.block_index);

  // effective pool size, clamped to the memory depth
  assign eff_cnt = (CMP_W'(block_count_r) > CMP_W'(MAX_BLOCKS)) ?
                   CNT_W'(MAX_BLOCKS) : CNT_W'(block_count_r);

  // sequencer and memory requests
  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    walk_nxt      = walk_r;
    last_nxt      = last_r;
    quiet_nxt     = quiet_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_INIT: begin
              if (eff_cnt == '0) begin
                free_head_nxt        = END_MARK;
                out_valid_nxt        = 1'b1;
                out_data_nxt.status  = STAT_OK;
              end else begin
                state_nxt = S_INIT;
                walk_nxt  = '0;
                last_nxt  = IDX_W'(eff_cnt - CNT_W'(1));
                quiet_nxt = 1'b0;
              end
            end
            OP_ALLOC: begin
              if (head_empty) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = free_head_r;
                state_nxt       = S_READ;
              end
            end
            OP_FREE: begin
              out_valid_nxt = 1'b1;
              if (CMP_W'(in_data.block_index) >= CMP_W'(eff_cnt)) begin
                out_data_nxt.status = STAT_RANGE;
              end else begin
                mem_req.wr_en       = 1'b1;
                mem_req.wr_addr     = free_idx;
                mem_req.wr_data     = free_head_r;
                free_head_nxt       = free_idx;
                out_data_nxt.status = STAT_OK;
              end
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STAT_OK;
            end
          endcase
        end
      end
      S_READ: begin
        // link of the granted block becomes the new head
        free_head_nxt              = mem_rd_data;
        out_valid_nxt              = 1'b1;
        out_data_nxt.status        = STAT_OK;
        out_data_nxt.granted_index = free_head_r[INDEX_W-1:0];
        state_nxt                  = S_IDLE;
      end
      S_INIT: begin
        // thread one block per cycle
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = LINK_W'(walk_r);
        if (walk_r == last_r) begin
          mem_req.wr_data     = END_MARK;
          free_head_nxt       = '0;
          state_nxt           = S_IDLE;
          out_valid_nxt       = !quiet_r;
          out_data_nxt.status = STAT_OK;
        end else begin
          mem_req.wr_data = LINK_W'(walk_r) + LINK_W'(1);
          walk_nxt        = walk_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      free_head_r <= '0;
      walk_r      <= '0;
      last_r      <= IDX_W'(RST_CNT - 1);
      quiet_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      walk_r      <= walk_nxt;
      last_r      <= last_nxt;
      quiet_r     <= quiet_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BLOCK_COUNT_W'(RST_BLOCK_COUNT);
    end else if (cfg_we) begin
      block_count_r <= cfg_wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a link read state returns to idle in the next cycle
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_IDLE)
    else $error("link read state held longer than one cycle");

  // a nonempty allocate makes the block busy, then returns its word
  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.opcode == OP_ALLOC && !head_empty |=> busy ##1 out_valid)
    else $error("allocate result missing");

  // the threading walk never passes the last block
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> walk_r <= last_r)
    else $error("init walk beyond pool");

  // a result word never appears while an item is still at work
  a_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");
`endif

endmodule

// File: tb/tb_fixed_block_free_list_allocator.sv
// testbench for the fixed block free-list allocator: directed and random command words
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam int unsigned POOL_MAX = 1024;
  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASE_WORDS = 90;
  localparam int unsigned PHASE_COUNT = 10;
  localparam int unsigned PRINT_CAP = 40;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  fbfl_in_t                 in_data;
  logic                     out_valid;
  fbfl_out_t                out_data;
  logic                     cfg_we;
  logic [BLOCK_COUNT_W-1:0] cfg_wdata;

  // allocator shadow state
  logic [BLOCK_COUNT_W-1:0] pool_count;
  logic [LINK_W-1:0]        pool_head;
  logic [LINK_W-1:0]        pool_link [POOL_MAX];
  logic [INDEX_W-1:0]       held_blocks [$];

  fbfl_out_t   expected_words [$];
  fbfl_out_t   want_word;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  int unsigned burst_left;
  bit          sender_gaps;

  fixed_block_free_list_allocator #(
    .MAX_BLOCKS(POOL_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // blocks that init threads, clamped to the link store depth
  function automatic int unsigned pool_size();
    return (pool_count > POOL_MAX) ? POOL_MAX : int'(pool_count);
  endfunction

  // thread 0..n-1 in order and point the head at block 0
  function automatic void thread_pool();
    int unsigned n;
    n = pool_size();
    if (n == 0) begin
      pool_head = END_MARK;
      return;
    end
    for (int unsigned i = 0; i + 1 < n; i++) pool_link[INDEX_W'(i)] = LINK_W'(i + 1);
    pool_link[INDEX_W'(n - 1)] = END_MARK;
    pool_head = '0;
  endfunction

  function automatic void reset_pool_model();
    for (int unsigned i = 0; i < POOL_MAX; i++) pool_link[INDEX_W'(i)] = '0;
    pool_count = BLOCK_COUNT_W'(RST_BLOCK_COUNT);
    thread_pool();
    held_blocks.delete();
  endfunction

  // apply one command word to the shadow pool and return the result word
  function automatic fbfl_out_t apply_command(fbfl_in_t w);
    fbfl_out_t r;
    r.status        = STAT_OK;
    r.granted_index = '0;
    case (w.opcode)
      OP_INIT: begin
        thread_pool();
        held_blocks.delete();
      end
      OP_ALLOC: begin
        if (pool_head == END_MARK || pool_head >= POOL_MAX) begin
          r.status = STAT_EMPTY;
        end else begin
          r.granted_index = pool_head[INDEX_W-1:0];
          held_blocks.push_back(pool_head[INDEX_W-1:0]);
          pool_head = pool_link[pool_head[INDEX_W-1:0]];
        end
      end
      OP_FREE: begin
        if (w.block_index >= pool_size()) begin
          r.status = STAT_RANGE;
        end else begin
          pool_link[w.block_index] = pool_head;
          pool_head = LINK_W'(w.block_index);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // check result words against the oldest expectation, then predict accepted words
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: status %0d index %0d",
                                    out_data.status, out_data.granted_index));
        end else begin
          want_word = expected_words.pop_front();
          if (out_data.status !== want_word.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want_word.status));
          if (out_data.granted_index !== want_word.granted_index)
            report_mismatch($sformatf("granted_index %0d, expected %0d",
                                      out_data.granted_index, want_word.granted_index));
        end
      end
      if (start && !busy) expected_words.push_back(apply_command(in_data));
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // send one command word, with random gaps between bursts when sender_gaps is set
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    fbfl_in_t    w;
    w.opcode      = op;
    w.block_index = idx;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_gaps) begin
        gap = $urandom_range(1, 7);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait until every result is in and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [BLOCK_COUNT_W-1:0] n);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_count = n;
  endtask

  // pool as left by reset: in-order allocation, push back, unused code
  task automatic test_reset_pool();
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '1);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, 10'd1);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, 10'd1023);
    send_word(OP_ALLOC, '0);
    send_word(OP_NONE, '1);
  endtask

  // pool sizes at the edges, empty pool, out of range frees
  task automatic test_count_extremes();
    // zero blocks: init leaves an empty list
    write_block_count('0);
    send_word(OP_INIT, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, '0);
    // one block
    write_block_count(11'd1);
    send_word(OP_INIT, '1);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, 10'd1);
    send_word(OP_FREE, '0);
    send_word(OP_ALLOC, '0);
    // count beyond the store clamps to its depth
    write_block_count('1);
    send_word(OP_INIT, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, 10'd1023);
    // two blocks, drained, then shrunk without init: range uses the current count
    write_block_count(11'd2);
    send_word(OP_INIT, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    write_block_count(11'd1);
    send_word(OP_FREE, 10'd1);
    send_word(OP_FREE, '0);
  endtask

  // one random word: mostly allocate and free of held blocks
  task automatic send_random_word();
    int unsigned        pick;
    int unsigned        slot;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    idx  = INDEX_W'($urandom_range(0, POOL_MAX - 1));
    if (pick < 45) begin
      send_word(OP_ALLOC, idx);
    end else if (pick < 85) begin
      if (held_blocks.size() != 0) begin
        slot = $urandom_range(0, held_blocks.size() - 1);
        idx  = held_blocks[slot];
        held_blocks.delete(slot);
      end else if (pool_size() != 0) begin
        idx = INDEX_W'($urandom_range(0, pool_size() - 1));
      end
      send_word(OP_FREE, idx);
    end else if (pick < 93) begin
      send_word(OP_FREE, idx);
    end else if (pick < 97) begin
      send_word(OP_INIT, idx);
    end else begin
      send_word(OP_NONE, idx);
    end
  endtask

  // random traffic over several pool sizes, mostly small
  task automatic test_random_phases();
    int unsigned              pick;
    logic [BLOCK_COUNT_W-1:0] n;
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) n = BLOCK_COUNT_W'(POOL_MAX);
      else if (pick == 1) n = BLOCK_COUNT_W'($urandom_range(POOL_MAX + 1, 2047));
      else if (pick == 2) n = BLOCK_COUNT_W'($urandom_range(1, 2));
      else n = BLOCK_COUNT_W'($urandom_range(3, 48));
      write_block_count(n);
      sender_gaps = (p % 3 != 2);
      send_word(OP_INIT, INDEX_W'($urandom_range(0, POOL_MAX - 1)));
      for (int unsigned k = 0; k < PHASE_WORDS; k++) send_random_word();
    end
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    burst_left     = 0;
    sender_gaps    = 1'b1;
    reset_pool_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_pool();
    test_count_extremes();
    test_random_phases();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_link_mem.sv
hw/rtl/fixed_block_free_list_allocator.sv
tb/tb_fixed_block_free_list_allocator.sv
